// ----- design/plm_pkg.sv -----
// ----------------------------------------------------------------------------
// plm_pkg
// Shared types and constants of the polyline miter stroker.
// ----------------------------------------------------------------------------
package plm_pkg;

	localparam int CoordW  = 32;                   // coordinate width, Q16.16
	localparam int DirW    = 32;                   // unit vector width, Q2.30
	localparam int HwW     = 31;                   // half width register
	localparam int LenW    = 34;                   // offset length, up to 2^33
	localparam int OffW    = 35;                   // offset magnitude
	localparam int MagW    = (CoordW + 1 > 33) ? CoordW + 1 : 33;
	localparam int SatW    = ((CoordW > OffW) ? CoordW : OffW) + 2;
	localparam int UnitW   = 64;                   // iterative unit data width
	localparam int CfgAddrW = 3;
	localparam int CfgDataW = 32;

	typedef enum logic {
		OP_SQRT,
		OP_DIV
	} plm_op_t;

	typedef struct packed {
		logic             start;
		plm_op_t          op;
		logic [UnitW-1:0] a;   // radicand or dividend
		logic [UnitW-1:0] b;   // divisor
	} plm_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [UnitW-1:0] result;
	} plm_stat_t;

	// p +/- off, clamped to the signed coordinate range
	function automatic logic signed [CoordW-1:0] sat_offset(
		input logic signed [CoordW-1:0] p,
		input logic [OffW-1:0]          off,
		input logic                     sub
	);
		logic signed [SatW-1:0] pe;
		logic signed [SatW-1:0] oe;
		logic signed [SatW-1:0] r;
		logic                   ovf;
		pe  = {{(SatW-CoordW){p[CoordW-1]}}, p};
		oe  = {{(SatW-OffW){1'b0}}, off};
		r   = sub ? (pe - oe) : (pe + oe);
		ovf = (r[SatW-1:CoordW-1] != {(SatW-CoordW+1){1'b0}}) &&
			(r[SatW-1:CoordW-1] != {(SatW-CoordW+1){1'b1}});
		if (!ovf) begin
			sat_offset = r[CoordW-1:0];
		end else if (r[SatW-1]) begin
			sat_offset = {1'b1, {(CoordW-1){1'b0}}};
		end else begin
			sat_offset = {1'b0, {(CoordW-1){1'b1}}};
		end
	endfunction

endpackage

// ----- design/plm_point_if.sv -----
// ----------------------------------------------------------------------------
// plm_point_if
// Point request channel: valid/ready with one polyline point.
// ----------------------------------------------------------------------------
interface plm_point_if
	import plm_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [CoordW-1:0] point_x;
	logic signed [CoordW-1:0] point_y;
	logic                     last_point;

	modport source(output valid, point_x, point_y, last_point, input ready);
	modport sink(input valid, point_x, point_y, last_point, output ready);
endinterface

// ----- design/plm_vertex_if.sv -----
// ----------------------------------------------------------------------------
// plm_vertex_if
// Vertex request channel: valid/ready with one strip vertex.
// ----------------------------------------------------------------------------
interface plm_vertex_if
	import plm_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [CoordW-1:0] vertex_x;
	logic signed [CoordW-1:0] vertex_y;
	logic                     degenerate;
	logic                     last_of_run;

	modport source(output valid, vertex_x, vertex_y, degenerate, last_of_run, input ready);
	modport sink(input valid, vertex_x, vertex_y, degenerate, last_of_run, output ready);
endinterface

// ----- design/plm_iter.sv -----
// ----------------------------------------------------------------------------
// plm_iter
// Shared iterative unit: floor square root (2 bits per cycle) and unsigned
// restoring division (1 quotient bit per cycle).
// ----------------------------------------------------------------------------
module plm_iter
	import plm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  plm_req_t  req,
	output plm_stat_t stat
);

	localparam int CntW = $clog2(UnitW);

	logic             busy_q;
	logic             done_q;
	plm_op_t          op_q;
	logic [CntW-1:0]  cnt_q;
	logic [UnitW:0]   rem_q;   // remainder, or radicand left over
	logic [UnitW-1:0] quo_q;   // quotient, or root
	logic [UnitW-1:0] num_q;   // dividend bits, or current root bit
	logic [UnitW-1:0] div_q;

	logic [UnitW:0]   trial;
	logic [UnitW:0]   sq_sum;

	assign trial  = {rem_q[UnitW-1:0], num_q[UnitW-1]};
	assign sq_sum = {1'b0, quo_q} + {1'b0, num_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				quo_q  <= '0;
				if (req.op == OP_DIV) begin
					rem_q <= '0;
					num_q <= req.a;
					div_q <= req.b;
					cnt_q <= CntW'(UnitW - 1);
				end else begin
					rem_q <= {1'b0, req.a};
					num_q <= {2'b01, {(UnitW-2){1'b0}}};
					div_q <= '0;
					cnt_q <= CntW'(UnitW / 2 - 1);
				end
			end else if (busy_q) begin
				if (op_q == OP_DIV) begin
					num_q <= {num_q[UnitW-2:0], 1'b0};
					if (trial >= {1'b0, div_q}) begin
						rem_q <= trial - {1'b0, div_q};
						quo_q <= {quo_q[UnitW-2:0], 1'b1};
					end else begin
						rem_q <= trial;
						quo_q <= {quo_q[UnitW-2:0], 1'b0};
					end
				end else begin
					num_q <= {2'b00, num_q[UnitW-1:2]};
					if (rem_q >= sq_sum) begin
						rem_q <= rem_q - sq_sum;
						quo_q <= {1'b0, quo_q[UnitW-1:1]} + num_q;
					end else begin
						quo_q <= {1'b0, quo_q[UnitW-1:1]};
					end
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy   = busy_q;
	assign stat.done   = done_q;
	assign stat.result = quo_q;

endmodule

// ----- design/polyline_miter_stroker.sv -----
// ----------------------------------------------------------------------------
// polyline_miter_stroker
// Strokes a polyline into triangle-strip vertex pairs with miter joins.
// ----------------------------------------------------------------------------
// Sequence: a first point is only stored and gives no vertex. A unit vector is
// normalized, then takes a square root and two divisions on the shared unit; a start
// pair needs one unit vector, an interior join a second one (for the tangent) plus a
// miter division, a last point adds its end pair, and output stalls add on top.
// A new point is taken only in the idle state, once the previous point is done.
// Reset (arst_n low) clears the line state and loads half_width with 1.0.
// ----------------------------------------------------------------------------
module polyline_miter_stroker
	import plm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CfgAddrW-1:0] paddr,
	input  logic [CfgDataW-1:0] pwdata,
	output logic [CfgDataW-1:0] prdata,
	output logic                pready,
	plm_point_if.sink           points,
	plm_vertex_if.source        vertices
);

	typedef enum logic [4:0] {
		S_IDLE, S_START, S_NORM, S_SQA, S_SQB, S_SQC, S_SQW,
		S_DX, S_DXW, S_DY, S_DYW, S_UDONE, S_JOIN,
		S_DOT1, S_DOT2, S_DOT3, S_LENW, S_PAIR,
		S_OFX1, S_OFX2, S_OFX3, S_OFY1, S_OFY2, S_OFY3, S_OUT, S_FINISH
	} state_t;

	state_t state_q;

	// configuration
	logic [HwW-1:0] hw_q;

	// line state
	logic signed [CoordW-1:0] prev_x_q, prev_y_q;
	logic signed [DirW-1:0]   pdir_x_q, pdir_y_q;
	logic [1:0]               cnt_q;

	// current point
	logic signed [CoordW-1:0] px_q, py_q;
	logic                     last_q;

	// unit vector sequence
	logic [MagW-1:0]        ua_q, ub_q;
	logic                   usx_q, usy_q;
	logic                   tan_q;    // working on the join tangent
	logic                   uok_q;
	logic [31:0]            root_q;
	logic [DirW-1:0]        qx_q, qy_q;
	logic signed [DirW-1:0] dx_q, dy_q, tx_q, ty_q;
	logic                   seg_ok_q;

	// shared multiplier
	logic signed [32:0] ma, mb;
	logic signed [65:0] mprod;
	logic [63:0]        prod_q;
	logic [63:0]        acc_q;

	// vertex pair being sent
	logic signed [CoordW-1:0] ppx_q, ppy_q;
	logic signed [DirW-1:0]   vx_q, vy_q;
	logic [LenW-1:0]          plen_q;
	logic                     pok_q;
	logic                     pair_last_q;
	logic                     fin_q;
	logic                     side_q;   // 0: minus side, 1: plus side
	logic [OffW-1:0]          offx_q, offy_q;

	// output register
	logic                     ovalid_q;
	logic signed [CoordW-1:0] ox_q, oy_q;
	logic                     odeg_q, olast_q;

	plm_req_t  req;
	plm_stat_t stat;

	plm_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.stat   (stat)
	);

	// point minus previous point, as magnitude and sign
	logic signed [CoordW:0] diff_x, diff_y;
	logic [CoordW:0]        mag_x, mag_y;
	assign diff_x = {px_q[CoordW-1], px_q} - {prev_x_q[CoordW-1], prev_x_q};
	assign diff_y = {py_q[CoordW-1], py_q} - {prev_y_q[CoordW-1], prev_y_q};
	assign mag_x  = diff_x[CoordW] ? (CoordW+1)'(0) - diff_x : diff_x;
	assign mag_y  = diff_y[CoordW] ? (CoordW+1)'(0) - diff_y : diff_y;

	// sum of the two directions for the tangent
	logic signed [DirW:0] tsum_x, tsum_y;
	logic [DirW:0]        tmag_x, tmag_y;
	assign tsum_x = {dx_q[DirW-1], dx_q} + {pdir_x_q[DirW-1], pdir_x_q};
	assign tsum_y = {dy_q[DirW-1], dy_q} + {pdir_y_q[DirW-1], pdir_y_q};
	assign tmag_x = tsum_x[DirW] ? (DirW+1)'(0) - tsum_x : tsum_x;
	assign tmag_y = tsum_y[DirW] ? (DirW+1)'(0) - tsum_y : tsum_y;

	// normalize window checks: keep the larger magnitude in [2^30, 2^31)
	logic [MagW-1:0] uor;
	logic            u_big, u_small;
	assign uor     = ua_q | ub_q;
	assign u_big   = uor[MagW-1:31] != '0;
	assign u_small = uor[MagW-1:30] == '0;

	// miter dot product, rounded to Q2.30
	logic signed [63:0] dsum;
	logic [63:0]        dround;
	logic [LenW-1:0]    dotv;
	logic               dot_bad;
	assign dsum    = $signed(acc_q) + $signed(prod_q);
	assign dround  = dsum + 64'sd536870912;
	assign dotv    = dround[LenW+29:30];
	assign dot_bad = (dsum <= 64'sd0) || (dround[63:30] == '0);

	// miter length clamp at 2^33
	logic [LenW-1:0] len_clamped;
	assign len_clamped = (stat.result[63:LenW] != '0 ||
		(stat.result[LenW-1] && stat.result[LenW-2:0] != '0)) ?
		{1'b1, {(LenW-1){1'b0}}} : stat.result[LenW-1:0];

	// offset component magnitudes
	logic [DirW-1:0] absx, absy;
	assign absx = vx_q[DirW-1] ? DirW'(0) - vx_q : vx_q;
	assign absy = vy_q[DirW-1] ? DirW'(0) - vy_q : vy_q;

	// offset sum: low partial in acc, high partial (x 2^17) in prod, round half up
	logic [64:0] onum;
	assign onum = {1'b0, acc_q} + {prod_q[47:0], 17'b0} + 65'd536870912;

	// multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			S_SQA: begin
				ma = {1'b0, ua_q[31:0]};
				mb = {1'b0, ua_q[31:0]};
			end
			S_SQB: begin
				ma = {1'b0, ub_q[31:0]};
				mb = {1'b0, ub_q[31:0]};
			end
			S_DOT1: begin
				ma = {dx_q[DirW-1], dx_q};
				mb = {tx_q[DirW-1], tx_q};
			end
			S_DOT2: begin
				ma = {dy_q[DirW-1], dy_q};
				mb = {ty_q[DirW-1], ty_q};
			end
			S_OFX1: begin
				ma = {16'b0, plen_q[16:0]};
				mb = {2'b0, absx[30:0]};
			end
			S_OFX2: begin
				ma = {16'b0, plen_q[33:17]};
				mb = {2'b0, absx[30:0]};
			end
			S_OFY1: begin
				ma = {16'b0, plen_q[16:0]};
				mb = {2'b0, absy[30:0]};
			end
			S_OFY2: begin
				ma = {16'b0, plen_q[33:17]};
				mb = {2'b0, absy[30:0]};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end
	assign mprod = ma * mb;

	// requests to the shared unit
	always_comb begin
		req.start = 1'b0;
		req.op    = OP_DIV;
		req.a     = '0;
		req.b     = '0;
		case (state_q)
			S_SQC: begin
				req.start = 1'b1;
				req.op    = OP_SQRT;
				req.a     = acc_q + prod_q;
			end
			S_DX: begin
				req.start = 1'b1;
				req.a     = {2'b0, ua_q[31:0], 30'b0} + {33'b0, root_q[31:1]};
				req.b     = {32'b0, root_q};
			end
			S_DY: begin
				req.start = 1'b1;
				req.a     = {2'b0, ub_q[31:0], 30'b0} + {33'b0, root_q[31:1]};
				req.b     = {32'b0, root_q};
			end
			S_DOT3: begin
				req.start = !dot_bad;
				req.a     = {3'b0, hw_q, 30'b0};
				req.b     = {{(UnitW-LenW){1'b0}}, dotv};
			end
			default: begin
				req.start = 1'b0;
			end
		endcase
	end

	// outgoing vertex for the current side
	logic                     sub_x, sub_y;
	logic signed [CoordW-1:0] vert_x, vert_y;
	logic                     out_free;
	assign sub_x    = vx_q[DirW-1] != !side_q;
	assign sub_y    = vy_q[DirW-1] != !side_q;
	assign vert_x   = pok_q ? sat_offset(ppx_q, offx_q, sub_x) : ppx_q;
	assign vert_y   = pok_q ? sat_offset(ppy_q, offy_q, sub_y) : ppy_q;
	assign out_free = !ovalid_q || vertices.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			hw_q     <= HwW'(65536);
			prev_x_q <= '0;
			prev_y_q <= '0;
			pdir_x_q <= '0;
			pdir_y_q <= '0;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			prod_q <= mprod[63:0];
			// S_OUT reloads the output register itself
			if (ovalid_q && vertices.ready && state_q != S_OUT) begin
				ovalid_q <= 1'b0;
			end
			if (psel && penable && pwrite && paddr[2] == 1'b0) begin
				hw_q <= pwdata[HwW-1:0];
			end
			case (state_q)
				S_IDLE: begin
					if (points.valid) begin
						px_q    <= points.point_x;
						py_q    <= points.point_y;
						last_q  <= points.last_point;
						state_q <= S_START;
					end
				end
				S_START: begin
					fin_q <= 1'b0;
					if (cnt_q == 2'd0) begin
						// first point: store it, nothing to emit yet
						prev_x_q <= px_q;
						prev_y_q <= py_q;
						pdir_x_q <= '0;
						pdir_y_q <= '0;
						cnt_q    <= last_q ? 2'd0 : 2'd1;
						state_q  <= S_IDLE;
					end else begin
						ua_q    <= MagW'(mag_x);
						ub_q    <= MagW'(mag_y);
						usx_q   <= diff_x[CoordW];
						usy_q   <= diff_y[CoordW];
						tan_q   <= 1'b0;
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (uor == '0) begin
						uok_q   <= 1'b0;
						state_q <= S_UDONE;
					end else if (u_big) begin
						ua_q <= ua_q >> 1;
						ub_q <= ub_q >> 1;
					end else if (u_small) begin
						ua_q <= ua_q << 1;
						ub_q <= ub_q << 1;
					end else begin
						state_q <= S_SQA;
					end
				end
				S_SQA: state_q <= S_SQB;
				S_SQB: begin
					acc_q   <= prod_q;
					state_q <= S_SQC;
				end
				S_SQC: state_q <= S_SQW;
				S_SQW: begin
					if (stat.done) begin
						root_q  <= stat.result[31:0];
						state_q <= S_DX;
					end
				end
				S_DX: state_q <= S_DXW;
				S_DXW: begin
					if (stat.done) begin
						qx_q    <= stat.result[DirW-1:0];
						state_q <= S_DY;
					end
				end
				S_DY: state_q <= S_DYW;
				S_DYW: begin
					if (stat.done) begin
						qy_q    <= stat.result[DirW-1:0];
						uok_q   <= 1'b1;
						state_q <= S_UDONE;
					end
				end
				S_UDONE: begin
					if (!tan_q) begin
						dx_q     <= usx_q ? DirW'(0) - qx_q : qx_q;
						dy_q     <= usy_q ? DirW'(0) - qy_q : qy_q;
						seg_ok_q <= uok_q;
						state_q  <= S_JOIN;
					end else begin
						tx_q <= usx_q ? DirW'(0) - qx_q : qx_q;
						ty_q <= usy_q ? DirW'(0) - qy_q : qy_q;
						if (uok_q) begin
							state_q <= S_DOT1;
						end else begin
							// directions cancel: degenerate pair at the joint
							ppx_q       <= prev_x_q;
							ppy_q       <= prev_y_q;
							pok_q       <= 1'b0;
							pair_last_q <= !last_q;
							side_q      <= 1'b0;
							state_q     <= S_PAIR;
						end
					end
				end
				S_JOIN: begin
					ppx_q       <= prev_x_q;
					ppy_q       <= prev_y_q;
					pair_last_q <= !last_q;
					side_q      <= 1'b0;
					if (cnt_q == 2'd1) begin
						// start pair along the first segment normal
						vx_q    <= DirW'(0) - dy_q;
						vy_q    <= dx_q;
						plen_q  <= LenW'(hw_q);
						pok_q   <= seg_ok_q;
						state_q <= S_PAIR;
					end else if (!seg_ok_q || (pdir_x_q == '0 && pdir_y_q == '0)) begin
						pok_q   <= 1'b0;
						state_q <= S_PAIR;
					end else begin
						ua_q    <= MagW'(tmag_x);
						ub_q    <= MagW'(tmag_y);
						usx_q   <= tsum_x[DirW];
						usy_q   <= tsum_y[DirW];
						tan_q   <= 1'b1;
						state_q <= S_NORM;
					end
				end
				S_DOT1: state_q <= S_DOT2;
				S_DOT2: begin
					acc_q   <= prod_q;
					state_q <= S_DOT3;
				end
				S_DOT3: begin
					ppx_q       <= prev_x_q;
					ppy_q       <= prev_y_q;
					pair_last_q <= !last_q;
					side_q      <= 1'b0;
					vx_q        <= DirW'(0) - ty_q;
					vy_q        <= tx_q;
					if (dot_bad) begin
						pok_q   <= 1'b0;
						state_q <= S_PAIR;
					end else begin
						state_q <= S_LENW;
					end
				end
				S_LENW: begin
					if (stat.done) begin
						plen_q  <= len_clamped;
						pok_q   <= 1'b1;
						state_q <= S_PAIR;
					end
				end
				S_PAIR: state_q <= pok_q ? S_OFX1 : S_OUT;
				S_OFX1: state_q <= S_OFX2;
				S_OFX2: begin
					acc_q   <= prod_q;
					state_q <= S_OFX3;
				end
				S_OFX3: begin
					offx_q  <= onum[64:30];
					state_q <= S_OFY1;
				end
				S_OFY1: state_q <= S_OFY2;
				S_OFY2: begin
					acc_q   <= prod_q;
					state_q <= S_OFY3;
				end
				S_OFY3: begin
					offy_q  <= onum[64:30];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						ox_q     <= vert_x;
						oy_q     <= vert_y;
						odeg_q   <= !pok_q;
						olast_q  <= pair_last_q && side_q;
						if (!side_q) begin
							side_q <= 1'b1;
						end else if (fin_q) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_FINISH: begin
					prev_x_q <= px_q;
					prev_y_q <= py_q;
					if (last_q) begin
						// end pair at this point, then the line is closed
						cnt_q       <= 2'd0;
						pdir_x_q    <= '0;
						pdir_y_q    <= '0;
						ppx_q       <= px_q;
						ppy_q       <= py_q;
						vx_q        <= DirW'(0) - dy_q;
						vy_q        <= dx_q;
						plen_q      <= LenW'(hw_q);
						pok_q       <= seg_ok_q;
						pair_last_q <= 1'b1;
						side_q      <= 1'b0;
						fin_q       <= 1'b1;
						state_q     <= S_PAIR;
					end else begin
						cnt_q    <= 2'd2;
						pdir_x_q <= seg_ok_q ? dx_q : '0;
						pdir_y_q <= seg_ok_q ? dy_q : '0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign points.ready         = state_q == S_IDLE;
	assign vertices.valid       = ovalid_q;
	assign vertices.vertex_x    = ox_q;
	assign vertices.vertex_y    = oy_q;
	assign vertices.degenerate  = odeg_q;
	assign vertices.last_of_run = olast_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {{(CfgDataW-HwW){1'b0}}, hw_q} : '0;

endmodule

// ----- dv/polyline_miter_stroker_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polyline_miter_stroker_test
// Self-checking bench for the miter-join stroker. Polylines go in on the point
// channel, and a bit-exact fixed-point predictor builds the expected strip
// vertices as each point is accepted. A monitor checks every vertex request
// in order. Phases switch half_width over the APB port and vary the idle and
// stall pressure on both channels.
// ----------------------------------------------------------------------------
module polyline_miter_stroker_test;
	import plm_pkg::*;

	localparam int    WATCHDOG_LIMIT = 20000;
	localparam int    SETTLE_CYCLES  = 600;    // covers a full interior join
	localparam int    MAX_REPORTS    = 10;
	localparam logic [CfgAddrW-1:0] HALF_WIDTH_ADDR = 3'd0;
	localparam logic [CfgAddrW-1:0] UNUSED_ADDR     = 3'd4;  // register 1: ignored
	localparam longint COORD_MAX = 64'sd2147483647;
	localparam longint COORD_MIN = -64'sd2147483648;
	localparam longint unsigned ONE_Q30   = 64'd1 << 30;
	localparam longint unsigned LEN_LIMIT = 64'd1 << 33;

	typedef struct packed {
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		logic                     lst;
	} point_t;

	typedef struct packed {
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		logic                     degen;
		logic                     lst;
	} vertex_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel, penable, pwrite;
	logic [CfgAddrW-1:0] paddr;
	logic [CfgDataW-1:0] pwdata;
	logic [CfgDataW-1:0] prdata;
	logic                pready;

	plm_point_if  pts();
	plm_vertex_if strip();

	polyline_miter_stroker u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.points  (pts),
		.vertices(strip)
	);

	always #2 clk = ~clk;

	// stimulus and expectations
	point_t  point_backlog[$];
	vertex_t strip_vertices[$];
	int      mismatches = 0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	int      quiet_cycles = 0;

	// predictor state
	longint unsigned half_w = 64'd65536;
	longint          prev_x, prev_y, dir_x, dir_y;
	int              seen;

	// random line walker
	logic signed [CoordW-1:0] walk_x = '0, walk_y = '0, back_x = '0, back_y = '0;

	// ---------------------------------------------------------------- predictor
	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned r = 0;
		longint unsigned b = 64'h4000_0000_0000_0000;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Q2.30 unit vector of a signed-magnitude delta; 0 when the delta is zero
	function automatic bit unit_vec(input longint unsigned mx, input bit sx,
		input longint unsigned my, input bit sy, output longint ux, output longint uy);
		longint unsigned len, qx, qy;
		ux = 0;
		uy = 0;
		if ((mx | my) == 0) return 1'b0;
		while ((mx | my) >= 64'h8000_0000) begin
			mx >>= 1;
			my >>= 1;
		end
		while ((mx | my) < ONE_Q30) begin
			mx <<= 1;
			my <<= 1;
		end
		len = isqrt(mx * mx + my * my);
		qx = ((mx << 30) + len / 2) / len;
		qy = ((my << 30) + len / 2) / len;
		ux = sx ? -longint'(qx) : longint'(qx);
		uy = sy ? -longint'(qy) : longint'(qy);
		return 1'b1;
	endfunction

	// p -/+ len*|c|, saturated to the coordinate range
	function automatic longint offset_coord(longint p, longint unsigned len, longint c,
		bit neg);
		longint unsigned cm;
		longint          off, room;
		cm  = (c < 0) ? longint'(-c) : longint'(c);
		off = longint'((len * cm + (ONE_Q30 >> 1)) >> 30);
		if ((c < 0) != neg) begin
			room = p - COORD_MIN;
			return (off > room) ? COORD_MIN : p - off;
		end
		room = COORD_MAX - p;
		return (off > room) ? COORD_MAX : p + off;
	endfunction

	function automatic void strip_pair(inout vertex_t v[4], inout int n, input longint px,
		input longint py, input longint vx, input longint vy, input longint unsigned len,
		input bit ok);
		if (!ok) begin
			v[n]   = '{CoordW'(px), CoordW'(py), 1'b1, 1'b0};
			v[n+1] = '{CoordW'(px), CoordW'(py), 1'b1, 1'b0};
		end else begin
			v[n]   = '{CoordW'(offset_coord(px, len, vx, 1)),
				CoordW'(offset_coord(py, len, vy, 1)), 1'b0, 1'b0};
			v[n+1] = '{CoordW'(offset_coord(px, len, vx, 0)),
				CoordW'(offset_coord(py, len, vy, 0)), 1'b0, 1'b0};
		end
		n += 2;
	endfunction

	// advance the line state by one accepted point and queue its vertices
	function automatic void stroke_point(point_t p);
		vertex_t         v[4];
		int              n = 0;
		longint          px, py, dx, dy, tx, ty, dot_raw;
		longint unsigned mx, my, tmx, tmy, len, dot;
		bit              sx, sy, seg_ok, ok;
		px = longint'(p.x);
		py = longint'(p.y);
		if (seen == 0) begin
			prev_x = px;
			prev_y = py;
			dir_x  = 0;
			dir_y  = 0;
			seen   = p.lst ? 0 : 1;
			return;
		end
		sx = px < prev_x;
		sy = py < prev_y;
		mx = sx ? prev_x - px : px - prev_x;
		my = sy ? prev_y - py : py - prev_y;
		seg_ok = unit_vec(mx, sx, my, sy, dx, dy);
		if (seen == 1) begin
			strip_pair(v, n, prev_x, prev_y, -dy, dx, half_w, seg_ok);
		end else begin
			// miter join at the previous point
			tx = 0;
			ty = 0;
			len = 0;
			ok = seg_ok && (dir_x != 0 || dir_y != 0);
			if (ok) begin
				tmx = (dx + dir_x < 0) ? -(dx + dir_x) : dx + dir_x;
				tmy = (dy + dir_y < 0) ? -(dy + dir_y) : dy + dir_y;
				ok = unit_vec(tmx, dx + dir_x < 0, tmy, dy + dir_y < 0, tx, ty);
			end
			if (ok) begin
				dot_raw = dx * tx + dy * ty;
				if (dot_raw <= 0) begin
					ok = 0;
				end else begin
					dot = (longint'(dot_raw) + (ONE_Q30 >> 1)) >> 30;
					if (dot == 0) begin
						ok = 0;
					end else begin
						len = (half_w << 30) / dot;
						if (len > LEN_LIMIT) len = LEN_LIMIT;
					end
				end
			end
			strip_pair(v, n, prev_x, prev_y, -ty, tx, len, ok);
		end
		prev_x = px;
		prev_y = py;
		dir_x  = seg_ok ? dx : 0;
		dir_y  = seg_ok ? dy : 0;
		seen   = 2;
		if (p.lst) begin
			strip_pair(v, n, px, py, -dy, dx, half_w, seg_ok);
			seen  = 0;
			dir_x = 0;
			dir_y = 0;
		end
		v[n-1].lst = 1'b1;
		for (int k = 0; k < n; k++) strip_vertices = {strip_vertices, v[k]};
	endfunction

	// ---------------------------------------------------------------- driver
	// valid holds until accepted; a new point is loaded only when the slot frees
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts.valid      <= 1'b0;
			pts.point_x    <= '0;
			pts.point_y    <= '0;
			pts.last_point <= 1'b0;
		end else begin
			if (pts.valid && pts.ready)
				stroke_point('{pts.point_x, pts.point_y, pts.last_point});
			if (!pts.valid || pts.ready) begin
				if (point_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					point_t p;
					p = point_backlog.pop_front();
					pts.valid      <= 1'b1;
					pts.point_x    <= p.x;
					pts.point_y    <= p.y;
					pts.last_point <= p.lst;
				end else begin
					pts.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip.ready <= 1'b0;
		end else begin
			if (strip.valid && strip.ready) begin
				if (strip_vertices.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected vertex x=%0d y=%0d", strip.vertex_x, strip.vertex_y);
				end else begin
					vertex_t e, a;
					e = strip_vertices.pop_front();
					a = '{strip.vertex_x, strip.vertex_y, strip.degenerate, strip.last_of_run};
					if (a !== e) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display({"vertex mismatch: exp x=%0d y=%0d dg=%b l=%b",
								" got x=%0d y=%0d dg=%b l=%b"},
								e.x, e.y, e.degen, e.lst, a.x, a.y, a.degen, a.lst);
					end
				end
			end
			strip.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ---------------------------------------------------------------- watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pts.valid && pts.ready) || (strip.valid && strip.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("polyline_miter_stroker_test: FAIL");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- stimulus
	task automatic cfg_write(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (addr == HALF_WIDTH_ADDR) half_w = data[HwW-1:0];
	endtask

	task automatic add_point(logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y,
		logic lst);
		point_t p;
		p = '{x, y, lst};
		point_backlog = {point_backlog, p};
	endtask

	// mostly short well-formed lines; occasional wild jumps, repeats, reversals
	task automatic add_random_line();
		int                       n, kind;
		logic signed [CoordW-1:0] x, y;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(0, 19);
			case (kind)
				0: begin
					x = $urandom;
					y = $urandom;
				end
				1: begin
					x = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
					y = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
				end
				2: begin
					x = walk_x;   // zero-length segment
					y = walk_y;
				end
				3: begin
					x = back_x;   // reversal
					y = back_y;
				end
				default: begin
					x = walk_x + ($signed($urandom) >>> $urandom_range(7, 31));
					y = walk_y + ($signed($urandom) >>> $urandom_range(7, 31));
				end
			endcase
			back_x = walk_x;
			back_y = walk_y;
			walk_x = x;
			walk_y = y;
			add_point(x, y, i == n - 1);
		end
	endtask

	// wait until every point is taken and every vertex has come back
	task automatic drain();
		while (point_backlog.size() != 0 || pts.valid || strip_vertices.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(int idle, int stall, logic [CfgDataW-1:0] hw, int n_pts);
		cfg_write(HALF_WIDTH_ADDR, hw);
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		while (point_backlog.size() < n_pts) add_random_line();
		drain();
	endtask

	initial begin
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		prev_x  = 0;
		prev_y  = 0;
		dir_x   = 0;
		dir_y   = 0;
		seen    = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed lines at the reset half width
		add_point(0, 0, 1);                        // one-point line
		add_point(0, 0, 0);                        // square corners
		add_point(32'sd655360, 0, 0);
		add_point(32'sd655360, 32'sd655360, 0);
		add_point(0, 32'sd655360, 1);
		add_point(32'sd5, 32'sd5, 0);              // zero-length start, join after it
		add_point(32'sd5, 32'sd5, 0);
		add_point(32'sd20, 32'sd5, 1);
		add_point(0, 0, 0);                        // reversed join
		add_point(32'sd100, 0, 0);
		add_point(0, 0, 1);
		add_point(0, 0, 0);                        // steep join, clamped miter
		add_point(32'sd100000, 0, 0);
		add_point(0, 32'sd1, 1);
		add_point(32'h8000_0000, 32'h8000_0000, 0); // coordinate extremes
		add_point(32'h7fff_ffff, 32'h7fff_ffff, 0);
		add_point(32'h8000_0000, 32'h7fff_ffff, 1);
		add_point(32'h7fff_ffff, 0, 0);            // zero-length end
		add_point(32'h7fff_ffff, 0, 1);
		drain();

		// the ignored register must not disturb half_width
		cfg_write(UNUSED_ADDR, 32'hdead_beef);

		random_phase(0, 0, 32'h7fff_ffff, 85);
		random_phase(88, 0, 32'h0000_0000, 85);
		random_phase(0, 88, $urandom, 85);
		random_phase(9, 9, $urandom_range(1, 32'h0010_0000), 85);

		if (mismatches == 0 && strip_vertices.size() == 0) begin
			$display("polyline_miter_stroker_test: PASS");
		end else begin
			$display("polyline_miter_stroker_test: FAIL");
		end
		$finish;
	end

endmodule
